// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/acss_pkg.sv =====
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types and constants of the ADC channel scale and smooth core.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int CMD_W    = 2;
    localparam int CH_W     = 4;
    localparam int RAW_W    = 12;
    localparam int VAL_W    = 32;
    localparam int COEFF_W  = 17;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 16;

    localparam logic [VAL_W-1:0]   GAIN_ONE  = 32'h0100_0000;
    localparam logic [COEFF_W-1:0] COEFF_ONE = 17'h1_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_GAIN   = 2'd1,
        CMD_OFFSET = 2'd2,
        CMD_COEFF  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_WRITTEN  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_SAMPLE   = 3'd0,
        KIND_DISABLED = 3'd1,
        KIND_GAIN     = 3'd2,
        KIND_OFFSET   = 3'd3,
        KIND_COEFF    = 3'd4,
        KIND_IGNORED  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CH_W-1:0]    channel;
        logic [RAW_W-1:0]   raw;
        logic [VAL_W-1:0]   param;
    } item_t;

endpackage

// ===== sv/acss_front.sv =====
// ----------------------------------------------------------------------------
// acss_front
// Input side: holds the channel enable mask, classifies each transaction
// and clamps filter coefficients before queuing.
// ----------------------------------------------------------------------------
module acss_front #(
    parameter int NUM_CHANNELS = acss_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = acss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [acss_pkg::MASK_W-1:0]    cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [acss_pkg::CMD_W-1:0]     cmd,
    input  logic [acss_pkg::CH_W-1:0]      channel,
    input  logic [acss_pkg::RAW_W-1:0]     raw_sample,
    input  logic [acss_pkg::VAL_W-1:0]     param_value,
    input  logic                           q_full,
    output logic                           q_push,
    output acss_pkg::item_t                q_item
);
    import acss_pkg::*;

    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    cmd_t              cmd_code;
    logic              in_range;
    logic [VAL_W-1:0]  coeff_clamped;

    assign mask_next = cfg_write ? cfg_data : mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign cmd_code = cmd_t'(cmd);
    assign in_range = ({1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign full     = q_full;
    assign q_push   = push && !q_full;

    always_comb
    begin
        priority if (param_value[VAL_W-1])
            coeff_clamped = '0;
        else if ($signed(param_value) > $signed(VAL_W'(COEFF_ONE)))
            coeff_clamped = VAL_W'(COEFF_ONE);
        else
            coeff_clamped = param_value;
    end

    always_comb
    begin
        q_item.channel = channel;
        q_item.raw     = raw_sample & RAW_MASK;
        q_item.param   = param_value;
        q_item.kind    = KIND_IGNORED;
        unique case (cmd_code)
            CMD_SAMPLE: q_item.kind = (in_range && mask_reg[channel]) ? KIND_SAMPLE
                                                                      : KIND_DISABLED;
            CMD_GAIN:   q_item.kind = in_range ? KIND_GAIN : KIND_IGNORED;
            CMD_OFFSET: q_item.kind = in_range ? KIND_OFFSET : KIND_IGNORED;
            CMD_COEFF:
            begin
                q_item.kind  = in_range ? KIND_COEFF : KIND_IGNORED;
                q_item.param = coeff_clamped;
            end
        endcase
    end

endmodule

// ===== sv/acss_queue.sv =====
// ----------------------------------------------------------------------------
// acss_queue
// Small register queue decoupling the classifier from the arithmetic
// sequencer.
// ----------------------------------------------------------------------------
module acss_queue #(
    parameter int DEPTH = acss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  acss_pkg::item_t data_in,
    output logic            full,
    input  logic            pop,
    output acss_pkg::item_t data_out,
    output logic            empty
);
    import acss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= data_in;
    end

endmodule

// ===== sv/acss_back.sv =====
// ----------------------------------------------------------------------------
// acss_back
// Arithmetic sequencer: per-channel tables, one shared 33x18 multiplier for
// normalization, gain and filter products, and the result register.
// ----------------------------------------------------------------------------
module acss_back #(
    parameter int NUM_CHANNELS = acss_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = acss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  acss_pkg::item_t                q_item,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [acss_pkg::STATUS_W-1:0]  status,
    output logic [acss_pkg::CH_W-1:0]      result_channel,
    output logic [acss_pkg::VAL_W-1:0]     instant_value,
    output logic [acss_pkg::VAL_W-1:0]     filtered_value
);
    import acss_pkg::*;

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam longint unsigned RAW_FULL = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam longint unsigned NORM_MUL = ((64'd1 << 24) + RAW_FULL / 2) / RAW_FULL;
    localparam int MA_W   = 33;
    localparam int MB_W   = 18;
    localparam int MP_W   = MA_W + MB_W;
    localparam int DIFF_W = 34;
    localparam int LO_W   = 17;
    localparam int PROD_W = 66;
    localparam int QSH    = 24;
    localparam int FSH    = 16;
    localparam int D_W    = VAL_W + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_NORM = 8'b0000_0010,
        S_MLO  = 8'b0000_0100,
        S_MHI  = 8'b0000_1000,
        S_SAT  = 8'b0001_0000,
        S_DIFF = 8'b0010_0000,
        S_FILT = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    kind_t                     kind_reg, kind_next;
    logic [CH_W-1:0]           ch_reg, ch_next;
    logic [RAW_W-1:0]          raw_reg, raw_next;
    logic [VAL_W-1:0]          param_reg, param_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic signed [VAL_W-1:0]   inst_reg, inst_next;
    logic signed [D_W-1:0]     d_reg, d_next;
    logic signed [VAL_W-1:0]   filt_new_reg, filt_new_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   status_reg, status_next;
    logic [CH_W-1:0]           out_ch_reg, out_ch_next;
    logic [VAL_W-1:0]          out_inst_reg, out_inst_next;
    logic [VAL_W-1:0]          out_filt_reg, out_filt_next;

    logic signed [VAL_W-1:0]   filt_tbl_reg   [NUM_CHANNELS];
    logic signed [VAL_W-1:0]   gain_tbl_reg   [NUM_CHANNELS];
    logic signed [VAL_W-1:0]   offset_tbl_reg [NUM_CHANNELS];
    logic [COEFF_W-1:0]        coeff_tbl_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]   loaded_reg;

    logic [IDX_W-1:0]          idx;
    logic signed [VAL_W-1:0]   filt_cur;
    logic signed [VAL_W-1:0]   gain_cur;
    logic signed [VAL_W-1:0]   offset_cur;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MP_W-1:0]    mul_p;
    logic signed [PROD_W-1:0]  scaled;
    logic signed [VAL_W-1:0]   sat_val;
    logic signed [MP_W-1:0]    step;
    logic                      slot_free;
    logic                      commit;

    assign idx        = ch_reg[IDX_W-1:0];
    assign filt_cur   = filt_tbl_reg[idx];
    assign gain_cur   = gain_tbl_reg[idx];
    assign offset_cur = offset_tbl_reg[idx];
    assign slot_free  = !out_valid_reg || pop;
    assign commit     = (state_reg == S_FIN) && slot_free;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_NORM:
            begin
                mul_a = MA_W'(NORM_MUL);
                mul_b = MB_W'(raw_reg);
            end
            S_MLO:
            begin
                mul_a = MA_W'(gain_cur);
                mul_b = {1'b0, diff_reg[LO_W-1:0]};
            end
            S_MHI:
            begin
                mul_a = MA_W'(gain_cur);
                mul_b = {diff_reg[DIFF_W-1], diff_reg[DIFF_W-1:LO_W]};
            end
            S_FILT:
            begin
                mul_a = d_reg;
                mul_b = {1'b0, coeff_tbl_reg[idx]};
            end
            S_IDLE, S_SAT, S_DIFF, S_FIN: ;
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign scaled = acc_reg >>> QSH;
    assign step   = mul_p >>> FSH;

    always_comb
    begin
        if (&scaled[PROD_W-QSH-1:VAL_W-1] || ~|scaled[PROD_W-QSH-1:VAL_W-1])
            sat_val = scaled[VAL_W-1:0];
        else if (acc_reg[PROD_W-1])
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        ch_next        = ch_reg;
        raw_next       = raw_reg;
        param_next     = param_reg;
        diff_next      = diff_reg;
        acc_next       = acc_reg;
        inst_next      = inst_reg;
        d_next         = d_reg;
        filt_new_next  = filt_new_reg;
        out_valid_next = out_valid_reg && !pop;
        status_next    = status_reg;
        out_ch_next    = out_ch_reg;
        out_inst_next  = out_inst_reg;
        out_filt_next  = out_filt_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_item.kind;
                    ch_next    = q_item.channel;
                    raw_next   = q_item.raw;
                    param_next = q_item.param;
                    state_next = (q_item.kind == KIND_SAMPLE) ? S_NORM : S_FIN;
                end
            end
            S_NORM:
            begin
                diff_next  = DIFF_W'(mul_p) - DIFF_W'(offset_cur);
                state_next = S_MLO;
            end
            S_MLO:
            begin
                acc_next   = PROD_W'(mul_p);
                state_next = S_MHI;
            end
            S_MHI:
            begin
                acc_next   = acc_reg + (PROD_W'(mul_p) <<< LO_W);
                state_next = S_SAT;
            end
            S_SAT:
            begin
                inst_next = sat_val;
                if (loaded_reg[idx])
                    state_next = S_DIFF;
                else
                begin
                    filt_new_next = sat_val;
                    state_next    = S_FIN;
                end
            end
            S_DIFF:
            begin
                d_next     = D_W'(inst_reg) - D_W'(filt_cur);
                state_next = S_FILT;
            end
            S_FILT:
            begin
                filt_new_next = filt_cur + step[VAL_W-1:0];
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_reg;
                    out_inst_next  = '0;
                    out_filt_next  = '0;
                    unique case (kind_reg)
                        KIND_SAMPLE:
                        begin
                            status_next   = ST_OK;
                            out_inst_next = inst_reg;
                            out_filt_next = filt_new_reg;
                        end
                        KIND_DISABLED: status_next = ST_DISABLED;
                        KIND_GAIN, KIND_OFFSET, KIND_COEFF, KIND_IGNORED:
                            status_next = ST_WRITTEN;
                        default: status_next = ST_WRITTEN;
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            loaded_reg    <= '0;
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                filt_tbl_reg[n]   <= '0;
                gain_tbl_reg[n]   <= GAIN_ONE;
                offset_tbl_reg[n] <= '0;
                coeff_tbl_reg[n]  <= COEFF_ONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                unique case (kind_reg)
                    KIND_SAMPLE:
                    begin
                        filt_tbl_reg[idx] <= filt_new_reg;
                        loaded_reg[idx]   <= 1'b1;
                    end
                    KIND_GAIN:   gain_tbl_reg[idx]   <= param_reg;
                    KIND_OFFSET: offset_tbl_reg[idx] <= param_reg;
                    KIND_COEFF:  coeff_tbl_reg[idx]  <= param_reg[COEFF_W-1:0];
                    KIND_DISABLED, KIND_IGNORED: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        ch_reg       <= ch_next;
        raw_reg      <= raw_next;
        param_reg    <= param_next;
        diff_reg     <= diff_next;
        acc_reg      <= acc_next;
        inst_reg     <= inst_next;
        d_reg        <= d_next;
        filt_new_reg <= filt_new_next;
        status_reg   <= status_next;
        out_ch_reg   <= out_ch_next;
        out_inst_reg <= out_inst_next;
        out_filt_reg <= out_filt_next;
    end

    assign empty          = !out_valid_reg;
    assign status         = status_reg;
    assign result_channel = out_ch_reg;
    assign instant_value  = out_inst_reg;
    assign filtered_value = out_filt_reg;

endmodule

// ===== sv/adc_channel_scale_and_smooth_core.sv =====
// A sample on a loaded channel runs the sequencer through NORM, MLO, MHI, SAT,
// DIFF, FILT and FIN; the first sample of a channel skips DIFF and FILT; other
// transactions go from IDLE to FIN. The sequencer shares one 33x18 multiplier
// and takes the next one in IDLE; the input queue takes pushes meanwhile.
// Reset (rst_n, async, active low) empties queue and result register and loads
// all channel tables with their defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
// adc_channel_scale_and_smooth_core
// Multichannel ADC scaling with offset, gain and first-order low-pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_channel_scale_and_smooth_core #(
    parameter int NUM_CHANNELS = acss_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = acss_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH  = acss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [acss_pkg::MASK_W-1:0]    cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [acss_pkg::CMD_W-1:0]     cmd,
    input  logic [acss_pkg::CH_W-1:0]      channel,
    input  logic [acss_pkg::RAW_W-1:0]     raw_sample,
    input  logic [acss_pkg::VAL_W-1:0]     param_value,
    output logic                           empty,
    input  logic                           pop,
    output logic [acss_pkg::STATUS_W-1:0]  status,
    output logic [acss_pkg::CH_W-1:0]      result_channel,
    output logic [acss_pkg::VAL_W-1:0]     instant_value,
    output logic [acss_pkg::VAL_W-1:0]     filtered_value
);
    import acss_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_item_in;
    item_t q_item_out;

    acss_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .channel     (channel),
        .raw_sample  (raw_sample),
        .param_value (param_value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item_in)
    );

    acss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_item_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_item_out),
        .empty    (q_empty)
    );

    acss_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_item_out),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .status         (status),
        .result_channel (result_channel),
        .instant_value  (instant_value),
        .filtered_value (filtered_value)
    );

    `ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, !q_empty)
    `ASSERT_IMPL(a_push_not_full, clk, rst_n, q_push, !q_full)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, q_pop, !q_pop)
    `ASSERT_IMPL(a_no_value_on_status, clk, rst_n, !empty && (status != ST_OK),
                 (instant_value == '0) && (filtered_value == '0))

endmodule
